[hdl/url_escape_byte_encoder_assert.svh]
// Assertion macros for the URL escape byte encoder.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef URL_ESCAPE_BYTE_ENCODER_ASSERT_SVH
`define URL_ESCAPE_BYTE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UBENC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define UBENC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define UBENC_ASSERT(lbl, prop, msg)
`define UBENC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[hdl/ubenc_pkg.sv]
// Shared types, constants and character functions of the URL escape byte encoder.
// No dependencies; the front, queue, back and top modules import this package.
package ubenc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Kind of escape run that one input byte turns into.
   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_HEX   = 3'd1,
      KIND_PCT   = 3'd2,
      KIND_SP    = 3'd3,
      KIND_NL    = 3'd4,
      KIND_LT    = 3'd5,
      KIND_GT    = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  text_byte;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [6:0] CH_PCT  = 7'h25;
   localparam logic [6:0] CH_TWO  = 7'h32;
   localparam logic [6:0] CH_FIVE = 7'h35;
   localparam logic [6:0] CH_SIX  = 7'h36;
   localparam logic [6:0] CH_SEMI = 7'h3B;
   localparam logic [6:0] CH_LT   = 7'h3C;
   localparam logic [6:0] CH_GT   = 7'h3E;
   localparam logic [6:0] CH_B    = 7'h62;
   localparam logic [6:0] CH_G    = 7'h67;
   localparam logic [6:0] CH_L    = 7'h6C;
   localparam logic [6:0] CH_N    = 7'h6E;
   localparam logic [6:0] CH_P    = 7'h70;
   localparam logic [6:0] CH_R    = 7'h72;
   localparam logic [6:0] CH_S    = 7'h73;
   localparam logic [6:0] CH_T    = 7'h74;

   function automatic logic [6:0] hex_digit(logic [3:0] nib);
      logic [6:0] c;
      begin
         if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
         end else begin
            c = 7'h37 + {3'b000, nib};
         end
         return c;
      end
   endfunction

   // Index of the final character of a run.
   function automatic logic [2:0] last_idx(kind_type k);
      logic [2:0] n;
      begin
         unique case (k)
            KIND_PLAIN: n = 3'd0;
            KIND_HEX:   n = 3'd2;
            KIND_PCT:   n = 3'd2;
            KIND_SP:    n = 3'd7;
            KIND_NL:    n = 3'd3;
            KIND_LT:    n = 3'd5;
            KIND_GT:    n = 3'd5;
            default:    n = 3'd0;
         endcase
         return n;
      end
   endfunction

   function automatic logic [6:0] char_at(kind_type k, logic [7:0] b, logic [2:0] i);
      logic [6:0] c;
      begin
         c = 7'h00;
         unique case (k)
            KIND_PLAIN: c = b[6:0];
            KIND_HEX: begin
               case (i)
                  3'd0:    c = CH_PCT;
                  3'd1:    c = hex_digit(b[7:4]);
                  default: c = hex_digit(b[3:0]);
               endcase
            end
            KIND_PCT: begin
               case (i)
                  3'd0:    c = CH_PCT;
                  3'd1:    c = CH_TWO;
                  default: c = CH_FIVE;
               endcase
            end
            KIND_SP: begin
               case (i)
                  3'd0:    c = CH_PCT;
                  3'd1:    c = CH_TWO;
                  3'd2:    c = CH_SIX;
                  3'd3:    c = CH_N;
                  3'd4:    c = CH_B;
                  3'd5:    c = CH_S;
                  3'd6:    c = CH_P;
                  default: c = CH_SEMI;
               endcase
            end
            KIND_NL: begin
               case (i)
                  3'd0:    c = CH_LT;
                  3'd1:    c = CH_B;
                  3'd2:    c = CH_R;
                  default: c = CH_GT;
               endcase
            end
            KIND_LT, KIND_GT: begin
               case (i)
                  3'd0:    c = CH_PCT;
                  3'd1:    c = CH_TWO;
                  3'd2:    c = CH_SIX;
                  3'd3:    c = (k == KIND_LT) ? CH_L : CH_G;
                  3'd4:    c = CH_T;
                  default: c = CH_SEMI;
               endcase
            end
            default: c = 7'h00;
         endcase
         return c;
      end
   endfunction

endpackage

[hdl/ubenc_req_if.sv]
// Input channel of the URL escape byte encoder: one text byte per transfer.
// Stands alone; no package dependency.
interface ubenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

[hdl/ubenc_rsp_if.sv]
// Result channel of the URL escape byte encoder: one escaped character per transfer.
// Stands alone; no package dependency.
interface ubenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_end;

   modport source (output valid, output out_char, output run_end, input ready);
   modport sink (input valid, input out_char, input run_end, output ready);
endinterface

[hdl/ubenc_front.sv]
// Front end: holds the mode register, accepts text bytes and classifies them.
// Depends on ubenc_pkg and ubenc_req_if.
module ubenc_front import ubenc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   ubenc_req_if.sink     req,
   input  q_status_type  q_status,
   output logic          push,
   output token_type     push_token
);

   logic post_mode_ff;
   logic post_mode_in;
   logic [7:0] b;
   logic plain;

   always_comb begin
      post_mode_in = csr_wr_en ? csr_wr_data : post_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_mode_ff <= 1'b0;
      end else begin
         post_mode_ff <= post_mode_in;
      end
   end

   assign b = req.text_byte;
   assign plain = (b >= 8'h20 && b <= 8'h25) || (b >= 8'h27 && b <= 8'h3B) ||
                  (b == 8'h3D) || (b >= 8'h3F && b <= 8'h7E);

   assign req.ready = !q_status.full;
   assign push = req.valid && !q_status.full;

   // Percent is escaped before anything else; entities only apply in post mode.
   always_comb begin
      push_token.text_byte = b;
      if (b == 8'h25) begin
         push_token.kind = KIND_PCT;
      end else if (post_mode_ff && b == 8'h20) begin
         push_token.kind = KIND_SP;
      end else if (post_mode_ff && b == 8'h0A) begin
         push_token.kind = KIND_NL;
      end else if (post_mode_ff && b == 8'h3C) begin
         push_token.kind = KIND_LT;
      end else if (post_mode_ff && b == 8'h3E) begin
         push_token.kind = KIND_GT;
      end else if (plain) begin
         push_token.kind = KIND_PLAIN;
      end else begin
         push_token.kind = KIND_HEX;
      end
   end

endmodule

[hdl/ubenc_queue.sv]
// Small token queue between the front end and the expansion back end.
// Depends on ubenc_pkg.
module ubenc_queue import ubenc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  token_type     push_token,
   input  logic          pop,
   output token_type     head,
   output q_status_type  status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type          q_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_token;
      end
   end

   assign head = q_ff[rd_ptr_ff];
   assign status.full = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

[hdl/ubenc_back.sv]
// Back end: expands the head token into characters, one per cycle while rsp is not
// stalled, into the output register. Depends on ubenc_pkg and ubenc_rsp_if.
module ubenc_back import ubenc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  token_type     head,
   input  q_status_type  q_status,
   output logic          pop,
   ubenc_rsp_if.source   rsp
);

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [6:0] char_ff, char_in;
   logic       end_ff, end_in;
   logic       advance;
   logic       load;
   logic       last;

   assign advance = !valid_ff || rsp.ready;
   assign load = advance && !q_status.empty;
   assign last = (idx_ff == last_idx(head.kind));
   assign pop = load && last;

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      char_in = char_ff;
      end_in = end_ff;
      if (advance) begin
         valid_in = load;
      end
      if (load) begin
         char_in = char_at(head.kind, head.text_byte, idx_ff);
         end_in = last;
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff <= end_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.run_end = end_ff;

endmodule

[hdl/url_escape_byte_encoder.sv]
// URL escape byte encoder, top level.
// Channels: req_bus takes one text byte per transfer; rsp_bus gives one
// escaped ASCII character per transfer, with run_end set on the last
// character of each byte's run. csr_wr_en/csr_wr_data write the post mode
// bit, which enables the HTML entity forms of space, newline, '<' and '>'.
// Write it only while no byte is in flight.
// The byte is first written into the token queue; its first character is then
// loaded from the queue head into the output register and offered on rsp_bus.
// Characters then follow one per cycle while rsp_bus is not stalled. A run has
// 1 character for pass-through, 3 for hex or percent, 4 for newline,
// 6 for '<' and '>', 8 for space; the single output register serves one run at a time.
// The front end keeps accepting bytes into a QUEUE_DEPTH entry token queue
// while the back end expands; req_bus.ready drops only when the queue is full.
// A stall on rsp_bus holds the current character and backs up the queue.
// Reset empties the queue, clears the output valid flag and clears post mode.
// Depends on ubenc_pkg, the two channel interfaces, the front, queue and
// back modules, and the assertion macro header.
`include "url_escape_byte_encoder_assert.svh"
module url_escape_byte_encoder import ubenc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   ubenc_req_if.sink   req_bus,
   ubenc_rsp_if.source rsp_bus
);

   q_status_type q_status;
   logic         push;
   token_type    push_token;
   logic         pop;
   token_type    head;

   ubenc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .q_status    (q_status),
      .push        (push),
      .push_token  (push_token)
   );

   ubenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   ubenc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

   // A token leaves the queue only when the final character of its run is loaded.
   `UBENC_ASSERT(a_pop_ends_run, pop |=> (rsp_bus.valid && rsp_bus.run_end), "pop without run end")
   // An accepted byte is in the queue at the next edge.
   `UBENC_ASSERT(a_push_lands, (req_bus.valid && req_bus.ready) |=> !q_status.empty, "lost push")
   `UBENC_ASSERT(a_queue_sane, !(q_status.full && q_status.empty), "queue full and empty")
   `UBENC_ASSERT_RST(a_reset_clear, reset |=> (!rsp_bus.valid && q_status.empty), "reset state")

endmodule
